// ----- rtl/core/spcr_pkg.sv -----
// ----------------------------------------------------------------------------
// spcr_pkg
// Shared types and constants for the stepper command parser and runner.
// ----------------------------------------------------------------------------
package spcr_pkg;

  // Width of the step count carried on the result word.
  localparam int STEPS_W = 31;

  // Stream word widths.
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 40;

  // Command characters.
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Byte class as decided by the front end.
  typedef enum logic [2:0] {
    CLS_PIPE,
    CLS_ENABLE,
    CLS_DIR,
    CLS_STEPS,
    CLS_DIGIT,
    CLS_BLANK,
    CLS_OTHER
  } byte_class_t;

  // One classified word handed from the front end to the back end.
  typedef struct packed {
    logic        is_tick;
    byte_class_t cls;
    logic        is_one;
    logic [3:0]  digit;
  } op_t;

endpackage

// ----- rtl/core/spcr_front.sv -----
// ----------------------------------------------------------------------------
// spcr_front
// Accepts input words and classifies command bytes into a registered op.
// ----------------------------------------------------------------------------
module spcr_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [spcr_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // [7:0] byte_value
  input  logic                              s_axis_tuser,   // [0] tick
  output logic                              op_valid,
  input  logic                              op_ready,
  output spcr_pkg::op_t                     op
);

  spcr_pkg::op_t dec;

  // Decode the incoming byte into its class.
  always_comb begin
    dec.is_tick = s_axis_tuser;
    dec.is_one  = (s_axis_tdata == spcr_pkg::CH_ONE);
    dec.digit   = 4'(s_axis_tdata - spcr_pkg::CH_ZERO);
    if (s_axis_tdata == spcr_pkg::CH_PIPE) begin
      dec.cls = spcr_pkg::CLS_PIPE;
    end else if (s_axis_tdata == spcr_pkg::CH_E) begin
      dec.cls = spcr_pkg::CLS_ENABLE;
    end else if (s_axis_tdata == spcr_pkg::CH_D) begin
      dec.cls = spcr_pkg::CLS_DIR;
    end else if (s_axis_tdata == spcr_pkg::CH_S) begin
      dec.cls = spcr_pkg::CLS_STEPS;
    end else if (s_axis_tdata inside {[spcr_pkg::CH_ZERO:spcr_pkg::CH_NINE]}) begin
      dec.cls = spcr_pkg::CLS_DIGIT;
    end else if (s_axis_tdata inside {spcr_pkg::CH_SPACE, spcr_pkg::CH_TAB,
                                      spcr_pkg::CH_LF, spcr_pkg::CH_VT,
                                      spcr_pkg::CH_FF, spcr_pkg::CH_CR}) begin
      dec.cls = spcr_pkg::CLS_BLANK;
    end else begin
      dec.cls = spcr_pkg::CLS_OTHER;
    end
  end

  // The stage takes a new word when empty or when its word moves on.
  assign s_axis_tready = !op_valid || op_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (s_axis_tready) begin
      op_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op <= dec;
    end
  end

endmodule

// ----- rtl/core/spcr_queue.sv -----
// ----------------------------------------------------------------------------
// spcr_queue
// Small first-in first-out queue of classified ops between front and back.
// ----------------------------------------------------------------------------
module spcr_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  spcr_pkg::op_t in_op,
  output logic          out_valid,
  input  logic          out_ready,
  output spcr_pkg::op_t out_op
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  spcr_pkg::op_t    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             push;
  logic             pop;

  assign in_ready  = (fill != CNT_W'(DEPTH));
  assign out_valid = (fill != '0);
  assign out_op    = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_op;
    end
  end

endmodule

// ----- rtl/core/spcr_back.sv -----
// ----------------------------------------------------------------------------
// spcr_back
// Executes classified ops: command parser, step runner and result register.
// ----------------------------------------------------------------------------
module spcr_back #(
  parameter int COUNT_BITS = 31
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              op_valid,
  output logic                              op_ready,
  input  spcr_pkg::op_t                     op,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] step_pulse, [1] direction_backward, [2] driver_enabled,
  // [33:3] steps_taken, [39:34] zero
  output logic [spcr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast    // run_finished
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_AFTER_E,
    MODE_AFTER_D,
    MODE_NUMBER
  } mode_t;

  localparam int WIDE_W = COUNT_BITS + 4;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  mode_t                 mode, mode_next;
  logic [COUNT_BITS-1:0] acc, acc_next;
  logic                  seen, seen_next;
  logic                  ended, ended_next;
  logic [COUNT_BITS-1:0] target, target_next;
  logic [COUNT_BITS-1:0] count, count_next;
  logic                  enable, enable_next;
  logic                  backward, backward_next;
  logic                  pulse_next;
  logic                  finished_next;
  logic                  do_cmd;
  logic [WIDE_W-1:0]     acc_wide;
  logic [WIDE_W-1:0]     acc_mac;
  logic [COUNT_BITS-1:0] acc_sat;
  logic                  take;

  // Accumulator times ten plus digit, saturated to the count range.
  assign acc_wide = WIDE_W'(acc);
  assign acc_mac  = (acc_wide << 3) + (acc_wide << 1) + WIDE_W'(op.digit);
  assign acc_sat  = (acc_mac[WIDE_W-1:COUNT_BITS] != '0) ? CNT_MAX
                                                          : acc_mac[COUNT_BITS-1:0];

  // An op executes when the result register is free or being drained.
  assign op_ready = !m_axis_tvalid || m_axis_tready;
  assign take     = op_valid && op_ready;

  // Next-state logic for one op.
  always_comb begin
    mode_next     = mode;
    acc_next      = acc;
    seen_next     = seen;
    ended_next    = ended;
    target_next   = target;
    count_next    = count;
    enable_next   = enable;
    backward_next = backward;
    pulse_next    = 1'b0;
    finished_next = 1'b0;
    do_cmd        = 1'b0;

    if (!op.is_tick) begin
      case (mode)
        MODE_AFTER_E: begin
          enable_next = op.is_one;
          mode_next   = MODE_IDLE;
          do_cmd      = 1'b1;
        end
        MODE_AFTER_D: begin
          backward_next = !op.is_one;
          mode_next     = MODE_IDLE;
          do_cmd        = 1'b1;
        end
        MODE_NUMBER: begin
          case (op.cls)
            spcr_pkg::CLS_PIPE: begin
              mode_next  = MODE_IDLE;
              acc_next   = '0;
              seen_next  = 1'b0;
              ended_next = 1'b0;
            end
            spcr_pkg::CLS_STEPS: begin
              if (seen) begin
                target_next = acc;
              end
              mode_next  = MODE_IDLE;
              acc_next   = '0;
              seen_next  = 1'b0;
              ended_next = 1'b0;
            end
            spcr_pkg::CLS_DIGIT: begin
              if (!ended) begin
                acc_next  = acc_sat;
                seen_next = 1'b1;
              end
            end
            spcr_pkg::CLS_BLANK: begin
              // Leading blanks are skipped; any later one ends the digits.
              if (seen || ended) begin
                ended_next = 1'b1;
              end
            end
            default: begin
              ended_next = 1'b1;
            end
          endcase
        end
        default: begin
          do_cmd = 1'b1;
        end
      endcase

      // Plain command handling, also applied to the argument byte of E and D.
      if (do_cmd) begin
        case (op.cls)
          spcr_pkg::CLS_PIPE: begin
            mode_next  = MODE_IDLE;
            acc_next   = '0;
            seen_next  = 1'b0;
            ended_next = 1'b0;
          end
          spcr_pkg::CLS_ENABLE: begin
            mode_next = MODE_AFTER_E;
          end
          spcr_pkg::CLS_DIR: begin
            mode_next = MODE_AFTER_D;
          end
          spcr_pkg::CLS_STEPS: begin
            mode_next  = MODE_NUMBER;
            acc_next   = '0;
            seen_next  = 1'b0;
            ended_next = 1'b0;
          end
          default: begin
          end
        endcase
      end
    end else if (target != '0) begin
      // Motion tick: step toward the target, or finish the move.
      if (count != target) begin
        count_next = count + 1'b1;
        pulse_next = 1'b1;
      end else begin
        target_next   = '0;
        count_next    = '0;
        enable_next   = 1'b0;
        finished_next = 1'b1;
      end
    end
  end

  // State and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      acc           <= '0;
      seen          <= 1'b0;
      ended         <= 1'b0;
      target        <= '0;
      count         <= '0;
      enable        <= 1'b0;
      backward      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (take) begin
        mode     <= mode_next;
        acc      <= acc_next;
        seen     <= seen_next;
        ended    <= ended_next;
        target   <= target_next;
        count    <= count_next;
        enable   <= enable_next;
        backward <= backward_next;
      end
      if (op_ready) begin
        m_axis_tvalid <= op_valid;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (take) begin
      m_axis_tdata <= {6'b0, spcr_pkg::STEPS_W'(count_next), enable_next, backward_next,
                       pulse_next};
      m_axis_tlast <= finished_next;
    end
  end

endmodule

// ----- rtl/core/stepper_command_parser_and_runner_unit.sv -----
// ----------------------------------------------------------------------------
// stepper_command_parser_and_runner_unit
// Single-axis stepper controller driven by command bytes and motion ticks.
// ----------------------------------------------------------------------------
// The block accepts one word every clock cycle while the output is not
// stalled and returns exactly one result word per input word, in order. A
// word goes through the classify register, a queue of QUEUE_DEPTH words and
// the execute stage, whose result register drives the output. The execute
// stage finishes one word per cycle while the output is not stalled; the
// classify register, the queue and the result register together hold
// QUEUE_DEPTH + 2 words, so the input keeps flowing after the output stalls
// until they are full. Commands: "E1" enables the driver (E with any other
// byte disables), "D1" selects forward (D with any other byte selects
// backward), "S<digits>S" loads the step target, "|" ends a frame. Each tick
// with an unmet nonzero target issues one step; a met target finishes the
// move, clears target and count and disables the driver, and that result
// word carries tlast.
// ----------------------------------------------------------------------------
module stepper_command_parser_and_runner_unit #(
  parameter int COUNT_BITS  = 31,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [spcr_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // [7:0] byte_value
  input  logic                              s_axis_tuser,   // [0] tick
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] step_pulse, [1] direction_backward, [2] driver_enabled,
  // [33:3] steps_taken, [39:34] zero
  output logic [spcr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast    // run_finished
);

  logic          front_valid;
  logic          front_ready;
  spcr_pkg::op_t front_op;
  logic          queue_valid;
  logic          queue_ready;
  spcr_pkg::op_t queue_op;

  spcr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .op_valid      (front_valid),
    .op_ready      (front_ready),
    .op            (front_op)
  );

  spcr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_op     (front_op),
    .out_valid (queue_valid),
    .out_ready (queue_ready),
    .out_op    (queue_op)
  );

  spcr_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .op_valid      (queue_valid),
    .op_ready      (queue_ready),
    .op            (queue_op),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ----- test/tb_stepper_command_parser_and_runner_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stepper_command_parser_and_runner_unit
// Self-checking bench for the stepper command parser and runner. A directed
// table runs first and covers reset levels, enable and direction commands,
// number parsing and a short move. Random command sequences and tick bursts
// follow. Each accepted input word is run through a behavioral copy of the
// controller, and every result word is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_stepper_command_parser_and_runner_unit;

  localparam int RANDOM_WORDS    = 1850;
  localparam int HOLD_OFF_AT     = 600;
  localparam int HOLD_OFF_CYCLES = 100;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 12;
  localparam longint unsigned COUNT_MAX = (64'd1 << spcr_pkg::STEPS_W) - 64'd1;

  typedef enum logic [1:0] {
    PARSE_IDLE,
    PARSE_AFTER_E,
    PARSE_AFTER_D,
    PARSE_NUMBER
  } parse_mode_t;

  // Levels reported on one result word, most significant field first.
  typedef struct packed {
    logic                         pulse;
    logic                         backward;
    logic                         enabled;
    logic                         finished;
    logic [spcr_pkg::STEPS_W-1:0] steps;
  } motor_levels_t;

  // One planned input word; a fixed result overrides the prediction.
  typedef struct packed {
    logic          is_tick;
    logic [7:0]    value;
    logic          fixed;
    motor_levels_t fixed_levels;
  } command_word_t;

  logic                            clk;
  logic                            rst;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [spcr_pkg::IN_DATA_W-1:0]  s_axis_tdata;   // [7:0] byte_value
  logic                            s_axis_tuser;   // [0] tick
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  // [0] step_pulse, [1] direction_backward, [2] driver_enabled,
  // [33:3] steps_taken, [39:34] zero
  logic [spcr_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tlast;   // run_finished

  command_word_t word_plan[$];
  motor_levels_t expected_levels[$];
  int            words_sent;
  int            error_count;
  int            idle_cycles;

  // Behavioral copy of the controller state.
  parse_mode_t                  parse_mode;
  logic [spcr_pkg::STEPS_W-1:0] number_acc;
  logic                         number_has_digit;
  logic                         number_closed;
  logic [spcr_pkg::STEPS_W-1:0] step_target;
  logic [spcr_pkg::STEPS_W-1:0] step_count;
  logic                         drive_enabled;
  logic                         drive_backward;

  stepper_command_parser_and_runner_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void clear_number();
    parse_mode       = PARSE_IDLE;
    number_acc       = '0;
    number_has_digit = 1'b0;
    number_closed    = 1'b0;
  endfunction

  // Interprets a byte as the start of a new command.
  function automatic void dispatch_byte(input logic [7:0] b);
    if (b == spcr_pkg::CH_PIPE) begin
      clear_number();
    end else if (b == spcr_pkg::CH_E) begin
      parse_mode = PARSE_AFTER_E;
    end else if (b == spcr_pkg::CH_D) begin
      parse_mode = PARSE_AFTER_D;
    end else if (b == spcr_pkg::CH_S) begin
      clear_number();
      parse_mode = PARSE_NUMBER;
    end
  endfunction

  // Applies one input word to the controller copy and returns its levels.
  function automatic motor_levels_t advance_motor(input logic is_tick, input logic [7:0] b);
    motor_levels_t   r;
    longint unsigned digit;
    logic            blank;
    r     = '0;
    digit = {56'd0, b - spcr_pkg::CH_ZERO};
    blank = (b == spcr_pkg::CH_SPACE) || (b == spcr_pkg::CH_TAB) ||
            (b == spcr_pkg::CH_LF) || (b == spcr_pkg::CH_VT) ||
            (b == spcr_pkg::CH_FF) || (b == spcr_pkg::CH_CR);
    if (!is_tick) begin
      case (parse_mode)
        PARSE_AFTER_E: begin
          // The argument byte is also parsed as a command of its own.
          drive_enabled = (b == spcr_pkg::CH_ONE);
          parse_mode = PARSE_IDLE;
          dispatch_byte(b);
        end
        PARSE_AFTER_D: begin
          drive_backward = (b != spcr_pkg::CH_ONE);
          parse_mode = PARSE_IDLE;
          dispatch_byte(b);
        end
        PARSE_NUMBER: begin
          if (b == spcr_pkg::CH_PIPE) begin
            clear_number();
          end else if (b == spcr_pkg::CH_S) begin
            if (number_has_digit) step_target = number_acc;
            clear_number();
          end else if (b >= spcr_pkg::CH_ZERO && b <= spcr_pkg::CH_NINE) begin
            // Only the first run of digits counts; the value saturates.
            if (!number_closed) begin
              if ({33'd0, number_acc} > (COUNT_MAX - digit) / 64'd10) begin
                number_acc = '1;
              end else begin
                number_acc = spcr_pkg::STEPS_W'({33'd0, number_acc} * 64'd10 + digit);
              end
              number_has_digit = 1'b1;
            end
          end else if (!(blank && !number_has_digit && !number_closed)) begin
            number_closed = 1'b1;
          end
        end
        default: begin
          dispatch_byte(b);
        end
      endcase
    end else if (step_target != '0) begin
      // The count wraps at the field width until it meets the target.
      if (step_count != step_target) begin
        step_count = step_count + 1'b1;
        r.pulse = 1'b1;
      end else begin
        step_target = '0;
        step_count = '0;
        drive_enabled = 1'b0;
        r.finished = 1'b1;
      end
    end
    r.backward = drive_backward;
    r.enabled  = drive_enabled;
    r.steps    = step_count;
    return r;
  endfunction

  function automatic void plan_word(input logic is_tick, input logic [7:0] value,
                                    input logic fixed, input motor_levels_t levels);
    command_word_t w;
    w.is_tick      = is_tick;
    w.value        = value;
    w.fixed        = fixed;
    w.fixed_levels = levels;
    word_plan.push_back(w);
  endfunction

  // Appends one random command sequence or burst of ticks to the plan.
  function automatic void plan_random_sequence();
    int kind;
    int digits;
    int pick;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      plan_word(1'b0, spcr_pkg::CH_E, 1'b0, '0);
      plan_word(1'b0, ($urandom_range(0, 9) < 6) ? spcr_pkg::CH_ONE : 8'($urandom), 1'b0, '0);
    end else if (kind < 20) begin
      plan_word(1'b0, spcr_pkg::CH_D, 1'b0, '0);
      plan_word(1'b0, ($urandom_range(0, 9) < 5) ? spcr_pkg::CH_ONE : 8'($urandom), 1'b0, '0);
    end else if (kind < 45) begin
      plan_word(1'b0, spcr_pkg::CH_S, 1'b0, '0);
      repeat ($urandom_range(0, 2)) begin
        case ($urandom_range(0, 5))
          0: plan_word(1'b0, spcr_pkg::CH_SPACE, 1'b0, '0);
          1: plan_word(1'b0, spcr_pkg::CH_TAB, 1'b0, '0);
          2: plan_word(1'b0, spcr_pkg::CH_LF, 1'b0, '0);
          3: plan_word(1'b0, spcr_pkg::CH_VT, 1'b0, '0);
          4: plan_word(1'b0, spcr_pkg::CH_FF, 1'b0, '0);
          default: plan_word(1'b0, spcr_pkg::CH_CR, 1'b0, '0);
        endcase
      end
      // Mostly short numbers so that moves complete; a few saturate.
      pick = $urandom_range(0, 99);
      if (pick < 5) digits = 0;
      else if (pick < 13) digits = $urandom_range(10, 12);
      else if (pick < 70) digits = 1;
      else digits = 2;
      repeat (digits) plan_word(1'b0, spcr_pkg::CH_ZERO + 8'($urandom_range(0, 9)),
                                1'b0, '0);
      // A random printable byte follows; unless it is a digit it ends the number, and any digits after it are ignored.
      if ($urandom_range(0, 4) == 0) begin
        plan_word(1'b0, 8'($urandom_range(33, 126)), 1'b0, '0);
        repeat ($urandom_range(0, 2)) plan_word(1'b0,
                                                spcr_pkg::CH_ZERO + 8'($urandom_range(0, 9)),
                                                1'b0, '0);
      end
      pick = $urandom_range(0, 19);
      if (pick < 17) plan_word(1'b0, spcr_pkg::CH_S, 1'b0, '0);
      else if (pick < 19) plan_word(1'b0, spcr_pkg::CH_PIPE, 1'b0, '0);
    end else if (kind < 85) begin
      repeat ($urandom_range(1, 12)) plan_word(1'b1, 8'($urandom), 1'b0, '0);
    end else if (kind < 95) begin
      plan_word(1'b0, 8'($urandom), 1'b0, '0);
    end else begin
      plan_word(1'b0, spcr_pkg::CH_PIPE, 1'b0, '0);
    end
  endfunction

  // Sender: walks the plan in bursts with random gaps between them.
  initial begin
    int            burst;
    int            gap;
    int            idx;
    int            directed_words;
    command_word_t w;
    motor_levels_t predicted;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    words_sent    = 0;
    error_count   = 0;
    clear_number();
    step_target    = '0;
    step_count     = '0;
    drive_enabled  = 1'b0;
    drive_backward = 1'b0;

    // Directed table: pulse, backward, enabled, finished, then steps.
    plan_word(1'b1, 8'h00, 1'b1, {4'b0000, 31'd0});          // tick after reset
    plan_word(1'b1, 8'hFF, 1'b1, {4'b0000, 31'd0});          // tick, zero target
    plan_word(1'b0, 8'hFF, 1'b1, {4'b0000, 31'd0});          // unknown byte
    plan_word(1'b0, spcr_pkg::CH_E, 1'b1, {4'b0000, 31'd0});
    plan_word(1'b0, spcr_pkg::CH_ONE, 1'b1, {4'b0010, 31'd0}); // enabled
    plan_word(1'b0, spcr_pkg::CH_D, 1'b1, {4'b0010, 31'd0});
    plan_word(1'b0, 8'h78, 1'b1, {4'b0110, 31'd0});          // backward
    plan_word(1'b0, spcr_pkg::CH_D, 1'b0, '0);
    plan_word(1'b0, spcr_pkg::CH_ONE, 1'b1, {4'b0010, 31'd0}); // forward
    plan_word(1'b0, spcr_pkg::CH_S, 1'b0, '0);
    plan_word(1'b0, spcr_pkg::CH_TAB, 1'b0, '0);             // leading blank
    plan_word(1'b0, spcr_pkg::CH_ZERO + 8'd3, 1'b0, '0);
    plan_word(1'b0, 8'h61, 1'b0, '0);                        // ends the number
    plan_word(1'b0, spcr_pkg::CH_ZERO + 8'd7, 1'b0, '0);     // ignored digit
    plan_word(1'b0, spcr_pkg::CH_S, 1'b0, '0);
    plan_word(1'b1, 8'h00, 1'b1, {4'b1010, 31'd1});
    plan_word(1'b1, 8'h00, 1'b1, {4'b1010, 31'd2});
    plan_word(1'b1, 8'h00, 1'b1, {4'b1010, 31'd3});
    plan_word(1'b1, 8'h00, 1'b1, {4'b0001, 31'd0});          // move complete
    plan_word(1'b0, spcr_pkg::CH_S, 1'b0, '0);               // no digits
    plan_word(1'b0, spcr_pkg::CH_S, 1'b0, '0);
    plan_word(1'b1, 8'h00, 1'b0, '0);
    plan_word(1'b0, spcr_pkg::CH_S, 1'b0, '0);               // frame end in number
    plan_word(1'b0, spcr_pkg::CH_ZERO + 8'd5, 1'b0, '0);
    plan_word(1'b0, spcr_pkg::CH_PIPE, 1'b0, '0);
    plan_word(1'b1, 8'h00, 1'b0, '0);
    plan_word(1'b0, spcr_pkg::CH_E, 1'b0, '0);               // disable, then frame end
    plan_word(1'b0, spcr_pkg::CH_PIPE, 1'b0, '0);
    directed_words = word_plan.size();
    while (word_plan.size() < directed_words + RANDOM_WORDS) plan_random_sequence();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    idx = 0;
    while (idx < word_plan.size()) begin
      burst = $urandom_range(1, 16);
      while (burst > 0 && idx < word_plan.size()) begin
        w = word_plan[idx];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w.value;
        s_axis_tuser  <= w.is_tick;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predicted = advance_motor(w.is_tick, w.value);
        expected_levels.push_back(w.fixed ? w.fixed_levels : predicted);
        words_sent++;
        idx++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (expected_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Receiver: random stall modes, plus one long hold-off that fills the block.
  initial begin
    int mode;
    int phase_cycles;
    bit held;
    m_axis_tready <= 1'b0;
    mode         = 0;
    phase_cycles = 0;
    held         = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && words_sent >= HOLD_OFF_AT) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        if (phase_cycles == 0) begin
          mode = $urandom_range(0, 3);
          phase_cycles = $urandom_range(20, 80);
        end
        phase_cycles--;
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ((phase_cycles % 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Compare each result word with the oldest expected levels.
  always @(posedge clk) begin : check_results
    motor_levels_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_levels.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, m_axis_tdata);
        error_count++;
      end else begin
        want = expected_levels.pop_front();
        if (m_axis_tdata[0] !== want.pulse) begin
          $display("%0t: step_pulse expected %0b actual %0b", $time, want.pulse,
                   m_axis_tdata[0]);
          error_count++;
        end
        if (m_axis_tdata[1] !== want.backward) begin
          $display("%0t: direction_backward expected %0b actual %0b", $time, want.backward,
                   m_axis_tdata[1]);
          error_count++;
        end
        if (m_axis_tdata[2] !== want.enabled) begin
          $display("%0t: driver_enabled expected %0b actual %0b", $time, want.enabled,
                   m_axis_tdata[2]);
          error_count++;
        end
        if (m_axis_tlast !== want.finished) begin
          $display("%0t: run_finished expected %0b actual %0b", $time, want.finished,
                   m_axis_tlast);
          error_count++;
        end
        if (m_axis_tdata[33:3] !== want.steps) begin
          $display("%0t: steps_taken expected %0d actual %0d", $time, want.steps,
                   m_axis_tdata[33:3]);
          error_count++;
        end
        if (m_axis_tdata[39:34] !== 6'd0) begin
          $display("%0t: padding expected 0 actual %h", $time, m_axis_tdata[39:34]);
          error_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when no word moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule

// ----- filelist.f -----
rtl/core/spcr_pkg.sv
rtl/core/spcr_front.sv
rtl/core/spcr_queue.sv
rtl/core/spcr_back.sv
rtl/core/stepper_command_parser_and_runner_unit.sv
test/tb_stepper_command_parser_and_runner_unit.sv
